// ===== hdl/lfd_pkg.sv =====
// Package for the link-format decoder: word types, codes and byte constants.
`timescale 1ns / 1ps

package lfd_pkg;

    // Default buffer length limit
    localparam int LFD_MAX_BYTES = 65535;

    // Token kinds on the result word
    localparam logic [1:0] KIND_TARGET = 2'd0;
    localparam logic [1:0] KIND_KEY    = 2'd1;
    localparam logic [1:0] KIND_VALUE  = 2'd2;
    localparam logic [1:0] KIND_DONE   = 2'd3;

    // Delimiter bytes
    localparam logic [7:0] CH_LT     = 8'h3C; // '<'
    localparam logic [7:0] CH_GT     = 8'h3E; // '>'
    localparam logic [7:0] CH_SEMI   = 8'h3B; // ';'
    localparam logic [7:0] CH_COMMA  = 8'h2C; // ','
    localparam logic [7:0] CH_EQ     = 8'h3D; // '='
    localparam logic [7:0] CH_QUOTE  = 8'h22; // '"'
    localparam logic [7:0] CH_BSLASH = 8'h5C; // backslash

    // Parser phases
    typedef enum logic [3:0] {
        PH_SEEK_LT,
        PH_SEEK_GT,
        PH_EXPECT_SEP,
        PH_KEY,
        PH_VAL_FIRST,
        PH_VAL_BARE,
        PH_VAL_QUOTED,
        PH_DRAIN
    } t_phase;

    // Input word
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_item;

    // Result word
    typedef struct packed {
        logic [1:0]  token_kind;
        logic [15:0] token_start;
        logic [15:0] token_length;
        logic [7:0]  attr_index;
        logic        status;
        logic [15:0] consumed;
        logic        last_result;
    } t_result;

    // Parser state carried from byte to byte
    typedef struct packed {
        t_phase      phase;
        logic [15:0] byte_offset;
        logic [15:0] token_begin;
        logic [7:0]  attr_count;
        logic        prev_bslash;
    } t_state;

endpackage

// ===== hdl/lfd_step.sv =====
// Per-byte parse step: next parser state and up to two result words.
`timescale 1ns / 1ps

module lfd_step #(
    parameter int MAX_BYTES = lfd_pkg::LFD_MAX_BYTES
) (
    input  lfd_pkg::t_state  i_state,
    input  lfd_pkg::t_item   i_item,
    input  logic [7:0]       i_max_attrs,
    output lfd_pkg::t_state  o_state,
    output lfd_pkg::t_result o_res0,
    output lfd_pkg::t_result o_res1,
    output logic [1:0]       o_nres
);
    import lfd_pkg::*;

    localparam logic [15:0] LAST_OFF = 16'(MAX_BYTES - 1);

    logic [7:0]  b;
    logic [15:0] off;
    logic [15:0] endpos;
    logic        fin;
    logic        is_delim;
    logic [7:0]  cnt_inc;
    logic        limit_hit;
    t_state      ns;
    logic        stop;
    logic        notfound;
    logic [15:0] cons;
    logic        do_close;
    logic [1:0]  close_kind;
    logic [15:0] close_start;
    logic        tok_v;
    t_result     tok;
    t_result     done;

    always_comb begin
        b         = i_item.data_byte;
        off       = i_state.byte_offset;
        endpos    = off + 16'd1;
        fin       = i_item.last_byte || (off >= LAST_OFF);
        is_delim  = (b == CH_SEMI) || (b == CH_COMMA);
        cnt_inc   = i_state.attr_count + 8'd1;
        limit_hit = (i_max_attrs != 8'd0) && (cnt_inc >= i_max_attrs);

        ns          = i_state;
        ns.byte_offset = endpos;
        stop        = 1'b0;
        notfound    = 1'b0;
        cons        = 16'd0;
        do_close    = 1'b0;
        close_kind  = KIND_KEY;
        close_start = i_state.token_begin;
        tok_v       = 1'b0;
        tok         = '0;
        done        = '0;

        // main phase decode
        case (i_state.phase)
            PH_SEEK_LT: begin
                if (b == CH_LT) begin
                    ns.token_begin = endpos;
                    ns.phase       = PH_SEEK_GT;
                end
            end
            PH_SEEK_GT: begin
                if (b == CH_GT) begin
                    tok_v            = 1'b1;
                    tok.token_kind   = KIND_TARGET;
                    tok.token_start  = i_state.token_begin;
                    tok.token_length = off - i_state.token_begin;
                    ns.phase         = PH_EXPECT_SEP;
                end
            end
            PH_EXPECT_SEP: begin
                if (b == CH_SEMI) begin
                    ns.token_begin = endpos;
                    ns.phase       = PH_KEY;
                end else begin
                    stop = 1'b1;
                    cons = off;
                end
            end
            PH_KEY: begin
                if (is_delim) begin
                    do_close = 1'b1;
                end else if (b == CH_EQ) begin
                    tok_v            = 1'b1;
                    tok.token_kind   = KIND_KEY;
                    tok.token_start  = i_state.token_begin;
                    tok.token_length = off - i_state.token_begin;
                    tok.attr_index   = i_state.attr_count;
                    ns.phase         = PH_VAL_FIRST;
                end
            end
            PH_VAL_FIRST: begin
                if (b == CH_QUOTE) begin
                    ns.token_begin = endpos;
                    ns.prev_bslash = 1'b0;
                    ns.phase       = PH_VAL_QUOTED;
                end else if (is_delim) begin
                    // empty bare value closed at once
                    do_close    = 1'b1;
                    close_kind  = KIND_VALUE;
                    close_start = off;
                end else begin
                    ns.token_begin = off;
                    ns.phase       = PH_VAL_BARE;
                end
            end
            PH_VAL_BARE: begin
                if (is_delim) begin
                    do_close   = 1'b1;
                    close_kind = KIND_VALUE;
                end
            end
            PH_VAL_QUOTED: begin
                if ((b == CH_QUOTE) && !i_state.prev_bslash) begin
                    tok_v            = 1'b1;
                    tok.token_kind   = KIND_VALUE;
                    tok.token_start  = i_state.token_begin;
                    tok.token_length = off - i_state.token_begin;
                    tok.attr_index   = i_state.attr_count;
                    ns.attr_count    = cnt_inc;
                    if (limit_hit) begin
                        stop = 1'b1;
                        cons = endpos;
                    end else begin
                        ns.phase = PH_EXPECT_SEP;
                    end
                end else begin
                    ns.prev_bslash = (b == CH_BSLASH);
                end
            end
            default: ;
        endcase

        // key or bare value ended by ';' or ','
        if (do_close) begin
            tok_v            = 1'b1;
            tok.token_kind   = close_kind;
            tok.token_start  = close_start;
            tok.token_length = off - close_start;
            tok.attr_index   = i_state.attr_count;
            ns.attr_count    = cnt_inc;
            if (!limit_hit && (b == CH_SEMI)) begin
                ns.token_begin = endpos;
                ns.phase       = PH_KEY;
            end else begin
                stop = 1'b1;
                cons = off;
            end
        end

        // end of buffer: repair a cut-off token
        if ((i_state.phase != PH_DRAIN) && !stop && fin) begin
            stop = 1'b1;
            cons = endpos;
            case (ns.phase)
                PH_SEEK_LT, PH_SEEK_GT: begin
                    notfound = 1'b1;
                    cons     = 16'd0;
                end
                PH_KEY: begin
                    if (ns.token_begin != endpos) begin
                        tok_v            = 1'b1;
                        tok.token_kind   = KIND_KEY;
                        tok.token_start  = ns.token_begin;
                        tok.token_length = endpos - ns.token_begin;
                        tok.attr_index   = ns.attr_count;
                    end
                    ns.attr_count = ns.attr_count + 8'd1;
                end
                PH_VAL_FIRST: begin
                    ns.attr_count = ns.attr_count + 8'd1;
                end
                PH_VAL_BARE, PH_VAL_QUOTED: begin
                    tok_v            = 1'b1;
                    tok.token_kind   = KIND_VALUE;
                    tok.token_start  = ns.token_begin;
                    tok.token_length = endpos - ns.token_begin;
                    tok.attr_index   = ns.attr_count;
                    ns.attr_count    = ns.attr_count + 8'd1;
                end
                default: ;
            endcase
        end

        // done word
        done.token_kind  = KIND_DONE;
        done.status      = notfound;
        done.attr_index  = notfound ? 8'd0 : ns.attr_count;
        done.consumed    = cons;
        done.last_result = 1'b1;
        tok.last_result  = !stop;

        // state after the byte
        if (i_state.phase == PH_DRAIN) begin
            tok_v = 1'b0;
            stop  = 1'b0;
            if (fin) begin
                ns = '{PH_SEEK_LT, 16'd0, 16'd0, 8'd0, 1'b0};
            end else begin
                ns = i_state;
                ns.byte_offset = endpos;
            end
        end else if (stop) begin
            if (fin) begin
                ns = '{PH_SEEK_LT, 16'd0, 16'd0, 8'd0, 1'b0};
            end else begin
                ns.phase       = PH_DRAIN;
                ns.byte_offset = endpos;
            end
        end

        o_state = ns;
        o_res0  = tok_v ? tok : done;
        o_res1  = done;
        o_nres  = {1'b0, tok_v} + {1'b0, stop};
    end

endmodule

// ===== hdl/lfd_out_buf.sv =====
// Two-entry result buffer: takes up to two words a cycle, hands out one while i_ready is high.
`timescale 1ns / 1ps

module lfd_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lfd_pkg::t_result i_push0,
    input  lfd_pkg::t_result i_push1,
    input  logic [1:0]       i_push_n,
    output logic [1:0]       o_space,
    output logic             o_valid,
    input  logic             i_ready,
    output lfd_pkg::t_result o_word
);
    import lfd_pkg::*;

    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    t_result    r_slot0;
    t_result    r_slot1;
    t_result    n_slot0;
    t_result    n_slot1;
    logic       pop;
    logic [1:0] cnt_ap;
    t_result    base0;

    // occupancy after this cycle's read
    always_comb begin
        pop     = (r_cnt != 2'd0) && i_ready;
        cnt_ap  = r_cnt - {1'b0, pop};
        o_space = 2'd2 - cnt_ap;
        o_valid = (r_cnt != 2'd0);
        o_word  = r_slot0;
    end

    // shift on read, append pushed words
    always_comb begin
        base0   = pop ? r_slot1 : r_slot0;
        n_slot0 = base0;
        n_slot1 = r_slot1;
        if (cnt_ap == 2'd0) begin
            n_slot0 = i_push0;
            n_slot1 = i_push1;
        end else if (cnt_ap == 2'd1) begin
            n_slot1 = i_push0;
        end
        n_cnt = cnt_ap + i_push_n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
    end

endmodule

// ===== hdl/link_format_decoder_top.sv =====
// Top level of the CoRE link-format decoder.
//
//  channel | dir | handshake                   | word
//  --------+-----+-----------------------------+-------------------------
//  in      | in  | i_in_valid / o_in_ready     | i_in_word (t_item)
//  out     | out | o_out_valid / i_out_ready   | o_out_word (t_result)
//  cfg     | in  | i_cfg_valid / o_cfg_ready   | i_cfg_max_attrs
//
// One byte a cycle while the result buffer has room; a byte that yields two
// results hands them out one at a time. The input register loads at the
// accept edge; the parse step then writes the two-entry result buffer once
// the buffer has room, and the first result is offered from its head slot.
// The step fires only when the buffer has room for all of a byte's results,
// so output stalls back up to o_in_ready. Reset is synchronous and clears the
// parser state, the limit register and both valid flags.
`timescale 1ns / 1ps

module link_format_decoder_top #(
    parameter int MAX_BYTES = lfd_pkg::LFD_MAX_BYTES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  lfd_pkg::t_item   i_in_word,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output lfd_pkg::t_result o_out_word,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [7:0]       i_cfg_max_attrs
);
    import lfd_pkg::*;

    logic       r_in_valid;
    t_item      r_in_word;
    t_state     r_state;
    t_state     n_state;
    logic [7:0] r_max_attrs;
    t_result    res0;
    t_result    res1;
    logic [1:0] nres;
    logic [1:0] space;
    logic       fire;
    logic       in_acc;

    // handshake
    assign fire        = r_in_valid && (nres <= space);
    assign o_in_ready  = !r_in_valid || fire;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_word <= i_in_word;
        end
    end

    // parser state and limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '{PH_SEEK_LT, 16'd0, 16'd0, 8'd0, 1'b0};
            r_max_attrs <= 8'd0;
        end else begin
            if (fire) begin
                r_state <= n_state;
            end
            if (i_cfg_valid) begin
                r_max_attrs <= i_cfg_max_attrs;
            end
        end
    end

    lfd_step #(
        .MAX_BYTES (MAX_BYTES)
    ) u_step (
        .i_state     (r_state),
        .i_item      (r_in_word),
        .i_max_attrs (r_max_attrs),
        .o_state     (n_state),
        .o_res0      (res0),
        .o_res1      (res1),
        .o_nres      (nres)
    );

    lfd_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push0  (res0),
        .i_push1  (res1),
        .i_push_n (fire ? nres : 2'd0),
        .o_space  (space),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_word   (o_out_word)
    );

endmodule

// ===== hdl/lfd_checker.sv =====
// Port-level checks for the link-format decoder, bound to the top level.
`timescale 1ns / 1ps

module lfd_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input lfd_pkg::t_result o_out_word
);
    import lfd_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed while stalled");

    // nothing is offered in the cycle after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered straight after reset");

    // not-found only on a done word, with nothing consumed
    a_notfound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.status |->
            (o_out_word.token_kind == KIND_DONE) && (o_out_word.consumed == 16'd0)
            && (o_out_word.attr_index == 8'd0))
        else $error("bad not-found word");

    // token words carry no status and no consumed count; done ends a byte
    a_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.token_kind != KIND_DONE) |->
            !o_out_word.status && (o_out_word.consumed == 16'd0))
        else $error("token word with done fields");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.token_kind == KIND_DONE) |->
            o_out_word.last_result && (o_out_word.token_length == 16'd0))
        else $error("done word not marked last");

endmodule

bind link_format_decoder_top lfd_checker u_lfd_checker (.*);

// ===== bench/link_format_decoder_top_tb.sv =====
// Self-checking bench for the link-format decoder: byte stream in, token words out.
`timescale 1ns / 1ps

module link_format_decoder_top_tb;

    import lfd_pkg::*;

    localparam int MAX_BYTES   = LFD_MAX_BYTES;
    localparam int HOLD_CYCLES = 200;
    localparam int QUIET_LIMIT = 2000;

    localparam t_result NO_WORD = '0;

    // One row of the directed table; pinned rows carry the final word by hand
    typedef struct packed {
        logic [7:0] data;
        logic       fin;
        logic       pinned;
        t_result    want;
    } t_row;

    localparam t_row DIR_ROWS [0:24] = '{
        // target then key cut off by the buffer end
        '{CH_LT,  1'b0, 1'b0, NO_WORD},
        '{CH_GT,  1'b0, 1'b1, '{KIND_TARGET, 16'd1, 16'd0, 8'd0, 1'b0, 16'd0, 1'b1}},
        '{CH_SEMI, 1'b0, 1'b0, NO_WORD},
        '{"k",    1'b1, 1'b1, '{KIND_DONE, 16'd0, 16'd0, 8'd1, 1'b0, 16'd4, 1'b1}},
        // no target at all
        '{"z",    1'b1, 1'b1, '{KIND_DONE, 16'd0, 16'd0, 8'd0, 1'b1, 16'd0, 1'b1}},
        // quoted value whose second backslash escapes the next quote, then a stop byte and drain
        '{CH_LT,  1'b0, 1'b0, NO_WORD},
        '{"a",    1'b0, 1'b0, NO_WORD},
        '{CH_GT,  1'b0, 1'b0, NO_WORD},
        '{CH_SEMI, 1'b0, 1'b0, NO_WORD},
        '{"k",    1'b0, 1'b0, NO_WORD},
        '{CH_EQ,  1'b0, 1'b0, NO_WORD},
        '{CH_QUOTE, 1'b0, 1'b0, NO_WORD},
        '{CH_BSLASH, 1'b0, 1'b0, NO_WORD},
        '{CH_BSLASH, 1'b0, 1'b0, NO_WORD},
        '{CH_QUOTE, 1'b0, 1'b0, NO_WORD},
        '{CH_QUOTE, 1'b0, 1'b0, NO_WORD},
        '{CH_COMMA, 1'b0, 1'b1, '{KIND_DONE, 16'd0, 16'd0, 8'd1, 1'b0, 16'd11, 1'b1}},
        '{"q",    1'b1, 1'b0, NO_WORD},
        // byte extremes, no target
        '{8'hFF,  1'b0, 1'b0, NO_WORD},
        '{8'h00,  1'b1, 1'b1, '{KIND_DONE, 16'd0, 16'd0, 8'd0, 1'b1, 16'd0, 1'b1}},
        // buffer ends right after the target
        '{CH_LT,  1'b0, 1'b0, NO_WORD},
        '{CH_GT,  1'b1, 1'b1, '{KIND_DONE, 16'd0, 16'd0, 8'd0, 1'b0, 16'd2, 1'b1}},
        // final ';' opens an empty attribute
        '{CH_LT,  1'b0, 1'b0, NO_WORD},
        '{CH_GT,  1'b0, 1'b0, NO_WORD},
        '{CH_SEMI, 1'b1, 1'b1, '{KIND_DONE, 16'd0, 16'd0, 8'd1, 1'b0, 16'd3, 1'b1}}
    };

    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       i_in_valid      = 1'b0;
    logic       o_in_ready;
    t_item      i_in_word       = '0;
    logic       o_out_valid;
    logic       i_out_ready     = 1'b0;
    t_result    o_out_word;
    logic       i_cfg_valid     = 1'b0;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_max_attrs = 8'd0;

    // side band that travels with each input word
    logic       pin_on   = 1'b0;
    t_result    pin_want = '0;

    // predictor state
    t_phase      scan_ph    = PH_SEEK_LT;
    logic [15:0] scan_pos   = '0;
    logic [15:0] tok_begin  = '0;
    logic [7:0]  attr_cnt   = '0;
    logic        esc_pend   = 1'b0;
    logic [7:0]  attr_limit = '0;

    t_result    tokens_due [$];
    t_result    byte_tokens [$];
    logic [7:0] pkt_q [$];
    int         pkt_junk;

    int mismatch_cnt  = 0;
    int in_idle_pct   = 0;
    int out_stall_pct = 0;
    int hold_req      = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int quiet         = 0;

    link_format_decoder_top #(
        .MAX_BYTES(MAX_BYTES)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in_word      (i_in_word),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_word     (o_out_word),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_max_attrs(i_cfg_max_attrs)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void clear_buffer();
        scan_ph   = PH_SEEK_LT;
        scan_pos  = '0;
        tok_begin = '0;
        attr_cnt  = '0;
        esc_pend  = 1'b0;
    endfunction

    function automatic void push_token(input logic [1:0] kind, input logic [15:0] start, len,
                                       input logic [7:0] idx, input logic st,
                                       input logic [15:0] cons);
        t_result r;
        r.token_kind   = kind;
        r.token_start  = start;
        r.token_length = len;
        r.attr_index   = idx;
        r.status       = st;
        r.consumed     = cons;
        r.last_result  = 1'b0;
        byte_tokens.push_back(r);
    endfunction

    // close an attribute; high when the limit is hit
    function automatic bit count_attr();
        attr_cnt = attr_cnt + 8'd1;
        return (attr_limit != 8'd0) && (attr_cnt >= attr_limit);
    endfunction

    // one buffer byte: advance the scan and queue the token words it yields
    function automatic void decode_byte(input t_item w);
        logic [15:0] off, endp, cons;
        logic [7:0]  b;
        logic        fin, stop, nf, again;
        t_result     t;
        byte_tokens.delete();
        off   = scan_pos;
        b     = w.data_byte;
        fin   = w.last_byte || (int'(off) >= MAX_BYTES - 1);
        endp  = off + 16'd1;
        stop  = 1'b0;
        nf    = 1'b0;
        cons  = '0;
        again = 1'b0;

        // swallowing the rest of a finished buffer
        if (scan_ph == PH_DRAIN) begin
            if (fin)
                clear_buffer();
            else
                scan_pos = endp;
            return;
        end

        do begin
            again = 1'b0;
            case (scan_ph)
                PH_SEEK_LT: begin
                    if (b == CH_LT) begin
                        tok_begin = endp;
                        scan_ph   = PH_SEEK_GT;
                    end
                end
                PH_SEEK_GT: begin
                    if (b == CH_GT) begin
                        push_token(KIND_TARGET, tok_begin, off - tok_begin, 8'd0, 1'b0, 16'd0);
                        scan_ph = PH_EXPECT_SEP;
                    end
                end
                PH_EXPECT_SEP: begin
                    if (b == CH_SEMI) begin
                        tok_begin = endp;
                        scan_ph   = PH_KEY;
                    end else begin
                        stop = 1'b1;
                        cons = off;
                    end
                end
                PH_KEY: begin
                    if (b == CH_SEMI || b == CH_COMMA) begin
                        push_token(KIND_KEY, tok_begin, off - tok_begin, attr_cnt, 1'b0, 16'd0);
                        if (count_attr()) begin
                            stop = 1'b1;
                            cons = off;
                        end else begin
                            scan_ph = PH_EXPECT_SEP;
                            again   = 1'b1;
                        end
                    end else if (b == CH_EQ) begin
                        push_token(KIND_KEY, tok_begin, off - tok_begin, attr_cnt, 1'b0, 16'd0);
                        scan_ph = PH_VAL_FIRST;
                    end
                end
                PH_VAL_FIRST: begin
                    if (b == CH_QUOTE) begin
                        tok_begin = endp;
                        esc_pend  = 1'b0;
                        scan_ph   = PH_VAL_QUOTED;
                    end else begin
                        tok_begin = off;
                        scan_ph   = PH_VAL_BARE;
                        again     = 1'b1;
                    end
                end
                PH_VAL_BARE: begin
                    if (b == CH_SEMI || b == CH_COMMA) begin
                        push_token(KIND_VALUE, tok_begin, off - tok_begin, attr_cnt, 1'b0, 16'd0);
                        if (count_attr()) begin
                            stop = 1'b1;
                            cons = off;
                        end else begin
                            scan_ph = PH_EXPECT_SEP;
                            again   = 1'b1;
                        end
                    end
                end
                default: begin
                    // quoted value: a quote after a backslash does not close it
                    if (b == CH_QUOTE && !esc_pend) begin
                        push_token(KIND_VALUE, tok_begin, off - tok_begin, attr_cnt, 1'b0, 16'd0);
                        if (count_attr()) begin
                            stop = 1'b1;
                            cons = endp;
                        end else begin
                            scan_ph = PH_EXPECT_SEP;
                        end
                    end else begin
                        esc_pend = (b == CH_BSLASH);
                    end
                end
            endcase
        end while (again && !stop);

        // buffer end: flush a cut-off token
        if (!stop && fin) begin
            stop = 1'b1;
            cons = endp;
            case (scan_ph)
                PH_SEEK_LT, PH_SEEK_GT: begin
                    nf   = 1'b1;
                    cons = '0;
                end
                PH_EXPECT_SEP: ;
                PH_KEY: begin
                    if (tok_begin != endp)
                        push_token(KIND_KEY, tok_begin, endp - tok_begin, attr_cnt, 1'b0, 16'd0);
                    void'(count_attr());
                end
                PH_VAL_FIRST: void'(count_attr());
                default: begin
                    push_token(KIND_VALUE, tok_begin, endp - tok_begin, attr_cnt, 1'b0, 16'd0);
                    void'(count_attr());
                end
            endcase
        end

        if (stop) begin
            if (nf)
                push_token(KIND_DONE, 16'd0, 16'd0, 8'd0, 1'b1, 16'd0);
            else
                push_token(KIND_DONE, 16'd0, 16'd0, attr_cnt, 1'b0, cons);
            if (fin) begin
                clear_buffer();
            end else begin
                scan_ph  = PH_DRAIN;
                scan_pos = endp;
            end
        end else begin
            scan_pos = endp;
        end

        foreach (byte_tokens[i]) begin
            t = byte_tokens[i];
            t.last_result = (i == byte_tokens.size() - 1);
            tokens_due.push_back(t);
        end
    endfunction

    // ------------------------------------------------------------------ checker

    function automatic string token_str(input t_result r);
        return $sformatf("kind %0d start %0d len %0d idx %0d st %0b cons %0d last %0b",
                         r.token_kind, r.token_start, r.token_length, r.attr_index,
                         r.status, r.consumed, r.last_result);
    endfunction

    function automatic void check_token(input t_result got);
        t_result want;
        if (tokens_due.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
                $display("%0t: word with none due: %s", $time, token_str(got));
            return;
        end
        want = tokens_due.pop_front();
        if (got !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
                $display("%0t: mismatch", $time);
                $display("  want %s", token_str(want));
                $display("  got  %s", token_str(got));
            end
        end
    endfunction

    // sample every handshake at the clock edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_buffer();
            attr_limit = '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready)
                attr_limit = i_cfg_max_attrs;
            if (i_in_valid && o_in_ready) begin
                decode_byte(i_in_word);
                if (pin_on && byte_tokens.size() != 0) begin
                    void'(tokens_due.pop_back());
                    tokens_due.push_back(pin_want);
                end
            end
            if (o_out_valid && i_out_ready)
                check_token(o_out_word);
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (hold_seen != hold_req) begin
            hold_seen   <= hold_req;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= out_stall_pct);
        end
    end

    // watchdog on cycles with no word moving anywhere
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("link_format_decoder_top_tb NOT OK");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus

    task automatic send_byte(input t_item w, input logic pin, input t_result want);
        while (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        pin_on     <= pin;
        pin_want   <= want;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic feed(input logic [7:0] b, input logic lst);
        send_byte('{data_byte: b, last_byte: lst}, 1'b0, NO_WORD);
    endtask

    task automatic send_pkt();
        foreach (pkt_q[i])
            feed(pkt_q[i], i == pkt_q.size() - 1);
    endtask

    // limit written only once the decoder has gone quiet
    task automatic write_limit(input logic [7:0] v);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (tokens_due.size() != 0);
        repeat (6) @(posedge i_clk);
        i_cfg_valid     <= 1'b1;
        i_cfg_max_attrs <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // token text: mostly letters, never a delimiter
    function automatic logic [7:0] plain_byte();
        logic [7:0] c;
        do begin
            c = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                         : 8'($urandom_range(8'h7A, 8'h61));
        end while (c == CH_LT || c == CH_GT || c == CH_SEMI || c == CH_COMMA ||
                   c == CH_EQ || c == CH_QUOTE || c == CH_BSLASH);
        return c;
    endfunction

    // one link-format buffer, mostly well formed, sometimes noise or broken
    function automatic void build_buffer();
        logic [7:0] c, prev;
        int         k;
        pkt_q.delete();
        pkt_junk = 0;
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(6, 1)) pkt_q.push_back(8'($urandom_range(255)));
            return;
        end
        repeat ($urandom_range(2)) pkt_q.push_back(8'($urandom_range(255)));
        pkt_q.push_back(CH_LT);
        repeat ($urandom_range(4)) pkt_q.push_back(plain_byte());
        pkt_q.push_back(CH_GT);
        repeat ($urandom_range(5)) begin
            pkt_q.push_back(CH_SEMI);
            repeat ($urandom_range(3)) pkt_q.push_back(plain_byte());
            case ($urandom_range(2))
                0: ;
                1: begin
                    pkt_q.push_back(CH_EQ);
                    repeat ($urandom_range(3)) pkt_q.push_back(plain_byte());
                end
                default: begin
                    pkt_q.push_back(CH_EQ);
                    pkt_q.push_back(CH_QUOTE);
                    prev = 8'h00;
                    repeat ($urandom_range(4)) begin
                        case ($urandom_range(4))
                            0: c = CH_BSLASH;
                            1: c = (prev == CH_BSLASH) ? CH_QUOTE : CH_SEMI;
                            2: c = CH_COMMA;
                            default: c = plain_byte();
                        endcase
                        pkt_q.push_back(c);
                        prev = c;
                    end
                    pkt_q.push_back(CH_QUOTE);
                end
            endcase
        end
        // tail: list separator or stray byte, then bytes to be drained
        case ($urandom_range(3))
            0: pkt_q.push_back(CH_COMMA);
            1: pkt_q.push_back(plain_byte());
            default: ;
        endcase
        if (pkt_q[pkt_q.size() - 1] != CH_GT || $urandom_range(1) == 0) begin
            pkt_junk = $urandom_range(3);
            repeat (pkt_junk) pkt_q.push_back(8'($urandom_range(255)));
        end
        // broken: cut short or one byte corrupted
        if ($urandom_range(4) == 0) begin
            if ($urandom_range(1) == 0) begin
                k = $urandom_range(pkt_q.size() - 1, 1);
                while (pkt_q.size() > k) void'(pkt_q.pop_back());
            end else begin
                pkt_q[$urandom_range(pkt_q.size() - 1)] = 8'($urandom_range(255));
            end
            pkt_junk = 0;
        end
    endfunction

    initial begin
        int         sent;
        logic [7:0] lim;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table, limit at its reset value
        foreach (DIR_ROWS[i])
            send_byte('{data_byte: DIR_ROWS[i].data, last_byte: DIR_ROWS[i].fin},
                      DIR_ROWS[i].pinned, DIR_ROWS[i].want);

        // receiver holds off while a key-heavy buffer keeps coming
        hold_req++;
        pkt_q = '{CH_LT, "a", CH_GT};
        repeat (12) begin
            pkt_q.push_back(CH_SEMI);
            pkt_q.push_back("k");
        end
        send_pkt();

        // 260 empty attributes: index and count wrap past 255
        pkt_q = '{CH_LT, "t", CH_GT};
        repeat (260) pkt_q.push_back(CH_SEMI);
        send_pkt();

        // random buffers over several limits and idling patterns
        for (int p = 0; p < 5; p++) begin
            case (p)
                0: lim = 8'd0;
                1: lim = 8'd1;
                2: lim = 8'd255;
                3: lim = 8'($urandom_range(4, 2));
                default: lim = 8'd2;
            endcase
            write_limit(lim);
            in_idle_pct   = (p == 1) ? 55 : (p == 3) ? 33 : 0;
            out_stall_pct = (p == 2) ? 55 : (p == 3) ? 33 : 0;
            sent = 0;
            while (sent < 32) begin
                build_buffer();
                send_pkt();
                sent += pkt_q.size() - pkt_junk;
            end
        end

        // drain and settle
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (tokens_due.size() != 0);
        repeat (8) @(posedge i_clk);
        if (mismatch_cnt == 0 && tokens_due.size() == 0)
            $display("link_format_decoder_top_tb OK");
        else
            $display("link_format_decoder_top_tb NOT OK");
        $finish;
    end

endmodule

// ===== link_format_decoder_top.f =====
hdl/lfd_pkg.sv
hdl/lfd_step.sv
hdl/lfd_out_buf.sv
hdl/link_format_decoder_top.sv
hdl/lfd_checker.sv
bench/link_format_decoder_top_tb.sv
